@@ rtl/aes_pkg.sv @@
package aes_pkg;

	typedef struct packed {
		logic [63:0] plaintext_high;
		logic [63:0] plaintext_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] ciphertext_high;
		logic [63:0] ciphertext_low;
	} aes_out_t;

	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// SubBytes + ShiftRows; byte 0 is the msb
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			t[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			t[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			t[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			t[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		mix_columns = t;
	endfunction

endpackage

@@ rtl/aes_key_expand.sv @@
module aes_key_expand #(
	parameter int ROUNDS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [127:0]                 key,
	output logic                         busy,
	output logic                         wr_en,
	output logic [$clog2(ROUNDS+1)-1:0]  wr_addr,
	output logic [127:0]                 wr_data
);
	import aes_pkg::*;

	localparam int AW = $clog2(ROUNDS + 1);

	logic          busy_q;
	logic [AW-1:0] idx_q;
	logic [127:0]  rk_q;
	logic [7:0]    rc_q;
	logic [31:0]   t;
	logic [127:0]  nxt;

	// one round key per cycle
	always_comb begin
		t = sub_word({rk_q[23:0], rk_q[31:24]}) ^ {rc_q, 24'h0};
		nxt[127:96] = rk_q[127:96] ^ t;
		nxt[95:64]  = rk_q[95:64] ^ nxt[127:96];
		nxt[63:32]  = rk_q[63:32] ^ nxt[95:64];
		nxt[31:0]   = rk_q[31:0] ^ nxt[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (idx_q == AW'(ROUNDS)) busy_q <= 1'b0;
			else idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rk_q <= '0;
			rc_q <= 8'h01;
		end else if (start) begin
			rk_q <= key;
			rc_q <= 8'h01;
		end else if (busy_q && idx_q != '0) begin
			rk_q <= nxt;
			rc_q <= xt(rc_q);
		end
	end

	// entry 0 is the key itself; the rest step from rk_q
	assign busy    = busy_q | start;
	assign wr_en   = busy_q && !start;
	assign wr_addr = idx_q;
	assign wr_data = (idx_q == '0) ? rk_q : nxt;

endmodule

@@ rtl/aes128_block_encryptor.sv @@
// channel   | valid/ready         | payload
// request   | in_valid/in_ready   | in_data (aes_in_t)
// result    | out_valid/out_ready | out_data (aes_out_t)
// config    | cfg_we              | cfg_index, cfg_data
// A block runs from accept to result valid as the initial key add and ten
// rounds, one registered round-key store read per round. No new request is taken
// until the block is back in idle, through ST_OUT while the output register is full.
// After reset and after every key write, key expansion fills the store one
// entry a cycle; no request is taken from the write until it ends.
// A result waits in the output register while the next block runs; the rounds
// stall at the end only while that register is still full.
module aes128_block_encryptor #(
	parameter int ROUNDS = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  aes_pkg::aes_in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output aes_pkg::aes_out_t out_data,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [63:0]     cfg_data
);
	import aes_pkg::*;

	localparam int AW = $clog2(ROUNDS + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [63:0]   key_high_q, key_low_q;
	logic          ke_start_q;
	logic          ke_busy, ke_we;
	logic [AW-1:0] ke_addr;
	logic [127:0]  ke_data;

	logic [127:0]  rk_mem [ROUNDS + 1];
	logic [127:0]  rk_rd_q;
	logic [AW-1:0] rd_addr;

	logic [1:0]    state_q;
	logic [AW-1:0] rnd_q;
	logic          first_q;
	logic [127:0]  st_q;
	logic [127:0]  pt_q;
	logic [127:0]  ss;
	logic [127:0]  rnd_out;

	logic          out_valid_q;
	logic [127:0]  out_q;
	logic          out_free;
	logic          fin;
	logic          load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			ke_start_q <= 1'b0;
		end else begin
			ke_start_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_HIGH: key_high_q <= cfg_data;
					REG_KEY_LOW:  key_low_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	aes_key_expand #(.ROUNDS(ROUNDS)) u_ke (
		.clk(clk), .arst_n(arst_n), .start(ke_start_q),
		.key({key_high_q, key_low_q}), .busy(ke_busy),
		.wr_en(ke_we), .wr_addr(ke_addr), .wr_data(ke_data)
	);

	assign in_ready = (state_q == ST_IDLE) && !ke_busy && !cfg_we;
	assign rd_addr  = (state_q == ST_IDLE) ? '0 : rnd_q;

	always_ff @(posedge clk) begin
		if (ke_we) rk_mem[ke_addr] <= ke_data;
		rk_rd_q <= rk_mem[rd_addr];
	end

	// rnd_q: round whose key is on rk_rd_q next cycle
	always_comb begin
		ss = sub_shift(st_q);
		if (first_q) rnd_out = pt_q ^ rk_rd_q;
		else if (rnd_q == AW'(ROUNDS)) rnd_out = mix_columns(ss) ^ rk_rd_q;
		else rnd_out = mix_columns(ss) ^ rk_rd_q;
		if (!first_q && rnd_q == '0) rnd_out = ss ^ rk_rd_q;
	end

	assign out_free = !out_valid_q || out_ready;
	assign fin      = (state_q == ST_RUN) && !first_q && (rnd_q == '0);
	assign load_out = (fin || state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					state_q <= ST_RUN;
					rnd_q   <= AW'(1);
					first_q <= 1'b1;
				end
				ST_RUN: begin
					first_q <= 1'b0;
					if (!first_q && rnd_q == '0) state_q <= out_free ? ST_IDLE : ST_OUT;
					else if (rnd_q == AW'(ROUNDS)) rnd_q <= '0;
					else rnd_q <= rnd_q + 1'b1;
				end
				ST_OUT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready)
			pt_q <= {in_data.plaintext_high, in_data.plaintext_low};
		if (state_q == ST_RUN) st_q <= rnd_out;
		if (load_out) out_q <= fin ? rnd_out : st_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ke_busy |-> !in_ready) else $error("request taken during key expansion");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_q))
		else $error("result lost");
	a_no_key_write_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !ke_we) else $error("store written mid block");

endmodule
